>>> design/dlrs_pkg.sv
package dlrs_pkg;

   // Longest marker the matcher supports, in bytes.
   localparam int MAX_MARKER_BYTES = 8;
   // Byte slots in one item: a full window plus the new byte.
   localparam int PKT_BYTES = MAX_MARKER_BYTES + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [63:0] START_MARKER_RESET = 64'h0029_2874_276E_6F64;
   localparam logic [3:0]  START_LEN_RESET    = 4'd7;
   localparam logic [63:0] END_MARKER_RESET   = 64'h0000_0000_2928_6F64;
   localparam logic [3:0]  END_LEN_RESET      = 4'd4;

   typedef enum logic [1:0] {
      CSR_START_MARKER     = 2'd0,
      CSR_START_MARKER_LEN = 2'd1,
      CSR_END_MARKER       = 2'd2,
      CSR_END_MARKER_LEN   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       line_last;
   } req_type;

   typedef struct packed {
      logic [7:0] kept_byte;
      logic       byte_valid;
      logic       line_done;
   } rsp_type;

   // Marker settings with lengths already clamped to 1..MAX_MARKER_BYTES.
   typedef struct packed {
      logic [63:0] start_marker;
      logic [3:0]  start_len;
      logic [63:0] end_marker;
      logic [3:0]  end_len;
   } cfg_type;

   // Bytes released by one accepted item, oldest in entry 0.
   typedef struct packed {
      logic [PKT_BYTES-1:0][7:0] bytes;
      logic [3:0]                count;
      logic                      line_last;
   } pkt_type;

   function automatic logic [3:0] clamp_len(logic [3:0] len);
      logic [3:0] res;
      res = len;
      if (len == 4'd0) begin
         res = 4'd1;
      end else if (len > 4'(MAX_MARKER_BYTES)) begin
         res = 4'(MAX_MARKER_BYTES);
      end
      return res;
   endfunction

endpackage

>>> design/delimited_region_stripper_core.sv
// Removes delimited regions from lines of text that arrive one byte per beat,
// with line_last set on the final byte of each line. A region runs from the
// leftmost start marker through the first end marker after it, both markers
// included; a start marker without an end marker removes the rest of the
// line, and every line starts over in the searching state. Markers are 1 to
// 8 bytes, first byte in bits 7:0, written through the csr_ port; the user
// must write them only while idle, which the block does not enforce (lengths
// of 0 act as 1, lengths above 8 act as 8). A new byte can be accepted on
// every clock unless the queue is full. Each byte yields zero or more result
// beats: normally one, but a line end may flush up to seven held bytes plus
// the new one and a shortened marker may release several at once; the result
// side drains one beat per cycle unless stalled. A four-entry queue between
// the byte matcher and the result sequencer absorbs those bursts; the request
// side stalls only when it is full. A result passes through a queue entry and
// the result register. A line whose final byte releases nothing still ends
// with one beat that has byte_valid low and line_done high.
module delimited_region_stripper_core (
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_stall,
   input  dlrs_pkg::req_type req_data,

   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dlrs_pkg::rsp_type rsp_data,

   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_wdata
);

   // Marker registers, as written by software.
   logic [63:0] start_marker_ff;
   logic [3:0]  start_len_ff;
   logic [63:0] end_marker_ff;
   logic [3:0]  end_len_ff;

   dlrs_pkg::cfg_type cfg;
   dlrs_pkg::pkt_type push_pkt, head_pkt;
   logic              take, push_valid, queue_full, head_valid, pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= dlrs_pkg::START_MARKER_RESET;
         start_len_ff    <= dlrs_pkg::START_LEN_RESET;
         end_marker_ff   <= dlrs_pkg::END_MARKER_RESET;
         end_len_ff      <= dlrs_pkg::END_LEN_RESET;
      end else if (csr_we) begin
         case (dlrs_pkg::csr_index_type'(csr_index))
            dlrs_pkg::CSR_START_MARKER: begin
               start_marker_ff <= csr_wdata;
            end
            dlrs_pkg::CSR_START_MARKER_LEN: begin
               start_len_ff <= csr_wdata[3:0];
            end
            dlrs_pkg::CSR_END_MARKER: begin
               end_marker_ff <= csr_wdata;
            end
            dlrs_pkg::CSR_END_MARKER_LEN: begin
               end_len_ff <= csr_wdata[3:0];
            end
            default: begin
            end
         endcase
      end
   end

   // The matcher sees clamped lengths so it never has to handle zero.
   always_comb begin
      cfg.start_marker = start_marker_ff;
      cfg.start_len    = dlrs_pkg::clamp_len(start_len_ff);
      cfg.end_marker   = end_marker_ff;
      cfg.end_len      = dlrs_pkg::clamp_len(end_len_ff);
   end

   // A byte is taken whenever the queue has room for what it may release.
   assign req_stall = queue_full;
   assign take      = req_valid && !queue_full;

   dlrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .take       (take),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_pkt   (push_pkt)
   );

   dlrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_pkt   (push_pkt),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_pkt   (head_pkt)
   );

   dlrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pkt   (head_pkt),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // A bare result beat only ever closes a line.
   a_bare_is_line_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.byte_valid) |-> rsp_data.line_done)
      else $error("bare result beat without line_done");

   // The byte on a bare beat is zero.
   a_bare_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.byte_valid) |-> (rsp_data.kept_byte == 8'd0))
      else $error("kept_byte nonzero on a bare beat");

   // Every accepted line end enters the queue in the same cycle.
   a_line_end_queued: assert property (@(posedge clock) disable iff (reset)
      (take && req_data.line_last) |-> (push_valid && push_pkt.line_last))
      else $error("line end accepted but not queued");

   // Nothing is pushed when no byte was taken.
   a_push_needs_take: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> take)
      else $error("queue push without an accepted byte");

endmodule

>>> design/dlrs_front.sv
module dlrs_front (
   input  logic              clock,
   input  logic              reset,
   input  dlrs_pkg::cfg_type cfg,
   input  logic              take,
   input  dlrs_pkg::req_type req_data,
   output logic              push_valid,
   output dlrs_pkg::pkt_type push_pkt
);

   logic                  removing_ff, removing_in;
   logic [2:0]            fill_ff, fill_in;
   logic [7:0]            window_ff [dlrs_pkg::MAX_MARKER_BYTES];

   logic [dlrs_pkg::PKT_BYTES-1:0][7:0] ext, sh_p, sh_q;
   logic [3:0]  len, fill_plus, p, q, n;
   logic [63:0] marker;
   logic        cmp_now, mismatch, matched, pop1;

   always_comb begin
      for (int i = 0; i < dlrs_pkg::PKT_BYTES; i++) begin
         if (i == int'(fill_ff)) begin
            ext[i] = req_data.text_byte;
         end else if (i < dlrs_pkg::MAX_MARKER_BYTES) begin
            ext[i] = window_ff[i];
         end else begin
            ext[i] = 8'd0;
         end
      end

      len       = removing_ff ? cfg.end_len : cfg.start_len;
      marker    = removing_ff ? cfg.end_marker : cfg.start_marker;
      fill_plus = {1'b0, fill_ff} + 4'd1;

      // Bytes that no longer fit the current marker length leave first.
      p    = (fill_plus > len) ? fill_plus - len : 4'd0;
      sh_p = ext >> {p, 3'b000};

      cmp_now  = ((fill_plus - p) == len);
      mismatch = 1'b0;
      for (int i = 0; i < dlrs_pkg::MAX_MARKER_BYTES; i++) begin
         if ((i < int'(len)) && (sh_p[i] != marker[8*i +: 8])) begin
            mismatch = 1'b1;
         end
      end
      matched = cmp_now && !mismatch;
      pop1    = cmp_now && mismatch;
      q       = p + {3'b000, pop1};
      sh_q    = ext >> {q, 3'b000};

      // Released bytes always form a prefix of the extended window.
      if (removing_ff) begin
         n = 4'd0;
      end else if (req_data.line_last && !matched) begin
         n = fill_plus;
      end else begin
         n = q;
      end

      push_valid         = take && ((n != 4'd0) || req_data.line_last);
      push_pkt.bytes     = ext;
      push_pkt.count     = n;
      push_pkt.line_last = req_data.line_last;

      if (matched || req_data.line_last) begin
         fill_in = 3'd0;
      end else begin
         fill_in = 3'(fill_plus - q);
      end
      removing_in = req_data.line_last ? 1'b0 : (removing_ff ^ matched);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         removing_ff <= 1'b0;
         fill_ff     <= 3'd0;
      end else if (take) begin
         removing_ff <= removing_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int i = 0; i < dlrs_pkg::MAX_MARKER_BYTES; i++) begin
            window_ff[i] <= sh_q[i];
         end
      end
   end

endmodule

>>> design/dlrs_queue.sv
module dlrs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dlrs_pkg::pkt_type push_pkt,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output dlrs_pkg::pkt_type head_pkt
);

   dlrs_pkg::pkt_type                entry_ff [dlrs_pkg::QUEUE_DEPTH];
   logic [dlrs_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dlrs_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dlrs_pkg::QUEUE_PTR_W:0]   count_ff, count_in;

   assign full       = (count_ff ==
                        (dlrs_pkg::QUEUE_PTR_W+1)'(dlrs_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_pkt   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (dlrs_pkg::QUEUE_PTR_W+1)'(push)
                           - (dlrs_pkg::QUEUE_PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_pkt;
      end
   end

endmodule

>>> design/dlrs_back.sv
module dlrs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  dlrs_pkg::pkt_type head_pkt,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dlrs_pkg::rsp_type rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   dlrs_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [3:0]        idx_ff, idx_in;
   logic [3:0]        last_idx;
   logic              advance, load, pkt_end;

   always_comb begin
      advance  = !rsp_valid_ff || !rsp_stall;
      load     = advance && head_valid;
      // A packet with no bytes still yields one bare end-of-line beat.
      last_idx = (head_pkt.count == 4'd0) ? 4'd0 : head_pkt.count - 4'd1;
      pkt_end  = (idx_ff == last_idx);
      pop      = load && pkt_end;

      rsp_data_in.byte_valid = (head_pkt.count != 4'd0);
      rsp_data_in.kept_byte  = rsp_data_in.byte_valid ? head_pkt.bytes[idx_ff] : 8'd0;
      rsp_data_in.line_done  = head_pkt.line_last && pkt_end;

      if (pop) begin
         idx_in = 4'd0;
      end else if (load) begin
         idx_in = idx_ff + 4'd1;
      end else begin
         idx_in = idx_ff;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
